@@ design/d8_flow_direction_defines.svh @@
// Assertion macros for the D8 flow direction block.
// Used by d8_flow_direction.sv; expects clk_i and rst_ni in scope.
`ifndef D8_FLOW_DIRECTION_DEFINES_SVH
`define D8_FLOW_DIRECTION_DEFINES_SVH

// property must hold at every clock edge out of reset
`define D8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("d8_flow_direction: assertion failed");

// expression must never be true out of reset
`define D8_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("d8_flow_direction: forbidden condition seen");

`endif

@@ design/d8_pkg.sv @@
// Constants for the D8 steepest-descent flow direction block.
// No dependencies.
`default_nettype none
package d8_pkg;
  localparam int unsigned HeightBitsDef = 24;
  localparam int unsigned NumDirs       = 8;
  localparam int unsigned DirBits       = 3;
  localparam int unsigned FlowBits      = 4;
  localparam int unsigned CardShift     = 16;
  localparam int unsigned DiagBits      = 17;
  localparam logic signed [DiagBits-1:0] DiagScale = 17'sd46341;
  localparam logic [FlowBits-1:0]        NoFlow    = 4'd8;
endpackage
`default_nettype wire

@@ design/d8_flow_direction.sv @@
// done_o follows start through valid regs s1_vld_q to s5_vld_q; one request accepted every cycle.
// Stages: height drops, slope scaling, two compare levels, final pick.
// The receiver cannot stall, so busy is always low.
// Reset (rst_ni low, async) clears all stage valid bits; data regs are not reset.
// Depends on d8_pkg and d8_flow_direction_defines.svh.
`default_nettype none
module d8_flow_direction #(
  parameter int unsigned HEIGHT_BITS = d8_pkg::HeightBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [HEIGHT_BITS-1:0] center_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] east_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] northeast_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] north_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] northwest_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] west_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] southwest_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] south_height_i,
  input  wire logic signed [HEIGHT_BITS-1:0] southeast_height_i,
  input  wire logic [d8_pkg::NumDirs-1:0]    inside_mask_i,
  output logic                               done_o,
  output logic [d8_pkg::FlowBits-1:0]        flow_dir_o
);
  import d8_pkg::*;

  `include "d8_flow_direction_defines.svh"

  localparam int unsigned DW = HEIGHT_BITS + 1;
  localparam int unsigned SW = DW + DiagBits;

  typedef struct packed {
    logic                 vld;
    logic signed [SW-1:0] slope;
    logic [DirBits-1:0]   dir;
  } cand_t;

  // later candidate b wins on greater slope, or on a tie when it is cardinal
  // and a is diagonal; matches an in-order scan
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.vld) begin
      if (!a.vld || (b.slope > a.slope) ||
          ((b.slope == a.slope) && !b.dir[0] && a.dir[0])) begin
        r = b;
      end
    end
    return r;
  endfunction

  logic signed [HEIGHT_BITS-1:0] nbr [NumDirs];
  assign nbr[0] = east_height_i;
  assign nbr[1] = northeast_height_i;
  assign nbr[2] = north_height_i;
  assign nbr[3] = northwest_height_i;
  assign nbr[4] = west_height_i;
  assign nbr[5] = southwest_height_i;
  assign nbr[6] = south_height_i;
  assign nbr[7] = southeast_height_i;

  assign busy = 1'b0;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic signed [DW-1:0] diff_d [NumDirs];
  logic signed [DW-1:0] diff_q [NumDirs];
  logic [NumDirs-1:0]   mask1_q;
  cand_t                s2_d [NumDirs];
  cand_t                s2_q [NumDirs];
  cand_t                s3_d [NumDirs/2];
  cand_t                s3_q [NumDirs/2];
  cand_t                s4_d [NumDirs/4];
  cand_t                s4_q [NumDirs/4];
  cand_t                best;
  logic [FlowBits-1:0]  flow_d, flow_q;

  always_comb begin
    for (int d = 0; d < NumDirs; d++) begin
      diff_d[d] = DW'(center_height_i) - DW'(nbr[d]);
    end
  end

  always_comb begin
    for (int d = 0; d < NumDirs; d++) begin
      s2_d[d].vld = mask1_q[d];
      s2_d[d].dir = DirBits'(d);
      if (d % 2 == 0) begin
        s2_d[d].slope = SW'(diff_q[d]) <<< CardShift;
      end else begin
        s2_d[d].slope = SW'(diff_q[d]) * SW'(DiagScale);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumDirs/2; i++) begin
      s3_d[i] = pick(s2_q[2*i], s2_q[2*i+1]);
    end
    for (int i = 0; i < NumDirs/4; i++) begin
      s4_d[i] = pick(s3_q[2*i], s3_q[2*i+1]);
    end
    best = pick(s4_q[0], s4_q[1]);
    flow_d = (best.vld && (best.slope > 0)) ? FlowBits'(best.dir) : NoFlow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    mask1_q <= inside_mask_i;
    s2_q    <= s2_d;
    s3_q    <= s3_d;
    s4_q    <= s4_d;
    flow_q  <= flow_d;
  end

  assign done_o     = s5_vld_q;
  assign flow_dir_o = flow_q;

  `D8_ASSERT(a_latency, start |-> ##5 done_o)
  `D8_ASSERT(a_no_spurious, done_o |-> $past(start, 5))
  `D8_ASSERT_NEVER(a_dir_range, done_o && (flow_dir_o > NoFlow))
  `D8_ASSERT(a_dead_end, (s4_vld_q && !s4_q[0].vld && !s4_q[1].vld) |=> (flow_dir_o == NoFlow))

endmodule
`default_nettype wire
